>>> src/damage_rect_accumulator_core_assert.svh
// Assertion macros used by the checker file of the damage accumulator.
`ifndef DAMAGE_RECT_ACCUMULATOR_CORE_ASSERT_SVH
`define DAMAGE_RECT_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define DRA_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define DRA_ASSERT_NXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> src/dra_pkg.sv
`default_nettype none

package dra_pkg;

	localparam int DIM_W        = 14;
	localparam int POS_W        = 14;
	localparam int OUT_POS_W    = 13;
	localparam int COORD_W      = 16;
	localparam int SUM_W        = 18;
	localparam int GEN_W        = 32;
	localparam int AREA_W       = 2 * DIM_W;
	localparam int BPP_W        = 4;
	localparam int WIDE_BYTES_W = AREA_W + BPP_W;
	localparam int BYTES_W      = 29;
	localparam int PCT_W        = 7;
	localparam int PROD_W       = AREA_W + PCT_W;
	localparam int CFG_ADDR_W   = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = 1;
	localparam int QCNT_W       = 2;

	localparam logic [PCT_W-1:0]   PCT_SCALE   = 7'd100;
	localparam logic [PCT_W-1:0]   PCT_RESET   = 7'd90;
	localparam logic [BYTES_W-1:0] LIMIT_RESET = 29'h1000_0000;

	localparam logic REG_PCT   = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		ACT_UPDATE,
		ACT_FULL,
		ACT_TAKE,
		ACT_CLEAR
	} act_t;

	typedef enum logic [2:0] {
		K_REJECT,
		K_RESYNC,
		K_MERGE,
		K_FULLREQ,
		K_TAKE,
		K_CLEAR
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MA,
		ST_MB,
		ST_MC,
		ST_FIN
	} state_t;

	typedef struct packed {
		act_t             action;
		logic [DIM_W-1:0] fw;
		logic [DIM_W-1:0] fh;
		logic [GEN_W-1:0] gen;
		logic             force_sync;
		logic             dims_ok;
		logic             clip_ok;
		logic [POS_W-1:0] cl;
		logic [POS_W-1:0] ct;
		logic [POS_W-1:0] cr;
		logic [POS_W-1:0] cb;
	} cmd_t;

	typedef struct packed {
		logic                 ok;
		logic                 full_frame;
		logic [OUT_POS_W-1:0] rect_left;
		logic [OUT_POS_W-1:0] rect_top;
		logic [DIM_W-1:0]     rect_width;
		logic [DIM_W-1:0]     rect_height;
		logic [BYTES_W-1:0]   byte_count;
		logic [GEN_W-1:0]     snapshot_generation;
	} res_t;

endpackage

`default_nettype wire

>>> src/dra_front.sv
`default_nettype none

module dra_front import dra_pkg::*; #(
	parameter int MAX_FRAME_DIM = 8192
) (
	input  logic                      push,
	output logic                      full,
	input  logic [1:0]                action,
	input  logic [DIM_W-1:0]          frame_width,
	input  logic [DIM_W-1:0]          frame_height,
	input  logic signed [COORD_W-1:0] dirty_left,
	input  logic signed [COORD_W-1:0] dirty_top,
	input  logic [COORD_W-1:0]        dirty_width,
	input  logic [COORD_W-1:0]        dirty_height,
	input  logic [GEN_W-1:0]          generation,
	input  logic                      force_resync,
	input  logic                      q_full,
	output logic                      q_wr,
	output cmd_t                      q_data
);

	localparam logic [DIM_W:0] MaxDim = MAX_FRAME_DIM[DIM_W:0];

	logic signed [SUM_W-1:0] xs, ys, xcl, ycl, xr, yr, fw_s, fh_s;
	logic                    dims_ok, clip_ok;

	assign full = q_full;
	assign q_wr = push && !q_full;

	always_comb begin
		// Clip the dirty rectangle to the frame with sign-extended arithmetic.
		xs   = $signed({{2{dirty_left[COORD_W-1]}}, dirty_left}) + $signed({2'b00, dirty_width});
		ys   = $signed({{2{dirty_top[COORD_W-1]}}, dirty_top}) + $signed({2'b00, dirty_height});
		xcl  = dirty_left[COORD_W-1] ? '0 : $signed({2'b00, dirty_left});
		ycl  = dirty_top[COORD_W-1] ? '0 : $signed({2'b00, dirty_top});
		fw_s = $signed({4'b0000, frame_width});
		fh_s = $signed({4'b0000, frame_height});
		xr   = (xs > fw_s) ? fw_s : xs;
		yr   = (ys > fh_s) ? fh_s : ys;

		clip_ok = (dirty_width != '0) && (dirty_height != '0) && (xr > xcl) && (yr > ycl);
		dims_ok = (frame_width != '0) && (frame_height != '0) &&
			({1'b0, frame_width} <= MaxDim) && ({1'b0, frame_height} <= MaxDim) &&
			(generation != '0);
	end

	always_comb begin
		q_data.action     = act_t'(action);
		q_data.fw         = frame_width;
		q_data.fh         = frame_height;
		q_data.gen        = generation;
		q_data.force_sync = force_resync;
		q_data.dims_ok    = dims_ok;
		q_data.clip_ok    = clip_ok;
		// Only meaningful when the clip is non-empty, which bounds them by the frame.
		q_data.cl         = xcl[POS_W-1:0];
		q_data.ct         = ycl[POS_W-1:0];
		q_data.cr         = xr[POS_W-1:0];
		q_data.cb         = yr[POS_W-1:0];
	end

endmodule

`default_nettype wire

>>> src/dra_queue.sv
`default_nettype none

module dra_queue import dra_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wp_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

>>> src/dra_back.sv
`default_nettype none

module dra_back import dra_pkg::*; #(
	parameter int BYTES_PER_PIXEL = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic               cmd_valid,
	output logic               cmd_pop,
	input  logic [PCT_W-1:0]   pct,
	input  logic [BYTES_W-1:0] limit,
	output logic               res_valid,
	input  logic               res_pop,
	output res_t               res
);

	localparam logic [BPP_W-1:0] Bpp = BYTES_PER_PIXEL[BPP_W-1:0];

	state_t state_q, next_state;

	// Architectural state.
	logic [DIM_W-1:0] sw_q, sh_q;
	logic [GEN_W-1:0] sg_q;
	logic             present_q;
	logic [POS_W-1:0] pl_q, pt_q;
	logic [DIM_W-1:0] pw_q, ph_q;
	logic             pv_q, pf_q;

	// Decision captured from the queue head.
	kind_t            kind_d, kind_q;
	logic [POS_W-1:0] bl_d, bt_d, bl_q, bt_q;
	logic [DIM_W-1:0] bw_d, bh_d, bw_q, bh_q;
	logic [DIM_W-1:0] cw_q, ch_q, nw_q, nh_q;
	logic [GEN_W-1:0] ng_q;

	// Products.
	logic [DIM_W-1:0]        mul_a, mul_b;
	logic [AREA_W-1:0]       mul_p, area_q, farea_q, carea_q;
	logic [PROD_W-1:0]       a100_q, fpct_q;
	logic [WIDE_BYTES_W-1:0] abytes_q, cbytes;

	logic             resync, promote, take_over, slot_free, fin_fire;
	logic [POS_W-1:0] ml, mt, mr, mb, pr, pb;
	res_t             res_d, res_q;
	logic             res_valid_q;

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign slot_free = !res_valid_q || res_pop;

	// Decision on the head item against the current state.
	always_comb begin
		resync = cmd.force_sync || (cmd.fw != sw_q) || (cmd.fh != sh_q) ||
			(cmd.gen != sg_q) || !cmd.clip_ok || !present_q;

		pr = pl_q + POS_W'(pw_q);
		pb = pt_q + POS_W'(ph_q);
		ml = cmd.cl;
		mt = cmd.ct;
		mr = cmd.cr;
		mb = cmd.cb;
		if (pv_q) begin
			if (pl_q < ml) ml = pl_q;
			if (pt_q < mt) mt = pt_q;
			if (pr > mr) mr = pr;
			if (pb > mb) mb = pb;
		end

		kind_d = K_REJECT;
		bl_d   = '0;
		bt_d   = '0;
		bw_d   = sw_q;
		bh_d   = sh_q;
		unique case (cmd.action)
			ACT_UPDATE: begin
				if (!cmd.dims_ok) begin
					kind_d = K_REJECT;
				end else if (resync) begin
					kind_d = K_RESYNC;
					bw_d   = cmd.fw;
					bh_d   = cmd.fh;
				end else begin
					kind_d = K_MERGE;
					bl_d   = ml;
					bt_d   = mt;
					bw_d   = DIM_W'(mr - ml);
					bh_d   = DIM_W'(mb - mt);
				end
			end
			ACT_FULL: begin
				if (cmd.gen == '0 || !present_q || sw_q == '0 || sh_q == '0) begin
					kind_d = K_REJECT;
				end else begin
					kind_d = K_FULLREQ;
				end
			end
			ACT_TAKE: begin
				if (!pv_q || !present_q) begin
					kind_d = K_REJECT;
				end else begin
					kind_d = K_TAKE;
					if (!pf_q) begin
						bl_d = pl_q;
						bt_d = pt_q;
						bw_d = pw_q;
						bh_d = ph_q;
					end
				end
			end
			ACT_CLEAR: kind_d = K_CLEAR;
			default:   kind_d = K_REJECT;
		endcase
	end

	// Next state.
	always_comb begin
		next_state = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (kind_d == K_RESYNC || kind_d == K_MERGE || kind_d == K_TAKE) begin
						next_state = ST_MA;
					end else begin
						next_state = ST_FIN;
					end
				end
			end
			ST_MA:  next_state = ST_MB;
			ST_MB:  next_state = (kind_q == K_MERGE) ? ST_MC : ST_FIN;
			ST_MC:  next_state = ST_FIN;
			ST_FIN: next_state = slot_free ? ST_IDLE : ST_FIN;
			default: next_state = ST_IDLE;
		endcase
	end

	// Sequencer outputs: queue pop, multiplier operands, completion.
	always_comb begin
		cmd_pop  = 1'b0;
		fin_fire = 1'b0;
		mul_a    = bw_q;
		mul_b    = bh_q;
		unique case (state_q)
			ST_IDLE: cmd_pop = cmd_valid;
			ST_MA: begin
				mul_a = bw_q;
				mul_b = bh_q;
			end
			ST_MB: begin
				mul_a = sw_q;
				mul_b = sh_q;
			end
			ST_MC: begin
				mul_a = cw_q;
				mul_b = ch_q;
			end
			ST_FIN:  fin_fire = slot_free;
			default: cmd_pop = 1'b0;
		endcase
	end

	assign mul_p     = AREA_W'(mul_a) * AREA_W'(mul_b);
	assign cbytes    = WIDE_BYTES_W'(carea_q) * WIDE_BYTES_W'(Bpp);
	assign promote   = (a100_q >= fpct_q);
	assign take_over = (abytes_q > WIDE_BYTES_W'(limit));

	// Result word for the item being finished.
	always_comb begin
		res_d = '0;
		unique case (kind_q)
			K_REJECT: res_d = '0;
			K_CLEAR:  res_d.ok = 1'b1;
			K_FULLREQ: begin
				res_d.ok          = 1'b1;
				res_d.full_frame  = 1'b1;
				res_d.rect_width  = sw_q;
				res_d.rect_height = sh_q;
			end
			K_TAKE: begin
				if (!take_over) begin
					res_d.ok                  = 1'b1;
					res_d.full_frame          = pf_q;
					res_d.rect_left           = bl_q[OUT_POS_W-1:0];
					res_d.rect_top            = bt_q[OUT_POS_W-1:0];
					res_d.rect_width          = bw_q;
					res_d.rect_height         = bh_q;
					res_d.byte_count          = pf_q ? '0 : abytes_q[BYTES_W-1:0];
					res_d.snapshot_generation = sg_q;
				end
			end
			K_RESYNC: begin
				res_d.ok          = 1'b1;
				res_d.full_frame  = 1'b1;
				res_d.rect_width  = nw_q;
				res_d.rect_height = nh_q;
				res_d.byte_count  = abytes_q[BYTES_W-1:0];
			end
			K_MERGE: begin
				res_d.ok         = 1'b1;
				res_d.full_frame = promote || pf_q;
				res_d.byte_count = cbytes[BYTES_W-1:0];
				if (promote) begin
					res_d.rect_width  = sw_q;
					res_d.rect_height = sh_q;
				end else begin
					res_d.rect_left   = bl_q[OUT_POS_W-1:0];
					res_d.rect_top    = bt_q[OUT_POS_W-1:0];
					res_d.rect_width  = bw_q;
					res_d.rect_height = bh_q;
				end
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			sw_q        <= '0;
			sh_q        <= '0;
			sg_q        <= '0;
			present_q   <= 1'b0;
			pl_q        <= '0;
			pt_q        <= '0;
			pw_q        <= '0;
			ph_q        <= '0;
			pv_q        <= 1'b0;
			pf_q        <= 1'b0;
		end else begin
			state_q <= next_state;
			if (fin_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
			if (fin_fire) begin
				unique case (kind_q)
					K_REJECT: pv_q <= pv_q;
					K_CLEAR: begin
						sw_q      <= '0;
						sh_q      <= '0;
						sg_q      <= '0;
						present_q <= 1'b0;
						pl_q      <= '0;
						pt_q      <= '0;
						pw_q      <= '0;
						ph_q      <= '0;
						pv_q      <= 1'b0;
						pf_q      <= 1'b0;
					end
					K_FULLREQ: begin
						sg_q <= ng_q;
						pl_q <= '0;
						pt_q <= '0;
						pw_q <= sw_q;
						ph_q <= sh_q;
						pv_q <= 1'b1;
						pf_q <= 1'b1;
					end
					K_TAKE: begin
						if (!take_over) begin
							pl_q <= '0;
							pt_q <= '0;
							pw_q <= '0;
							ph_q <= '0;
							pv_q <= 1'b0;
							pf_q <= 1'b0;
						end
					end
					K_RESYNC: begin
						sw_q      <= nw_q;
						sh_q      <= nh_q;
						sg_q      <= ng_q;
						present_q <= 1'b1;
						pl_q      <= '0;
						pt_q      <= '0;
						pw_q      <= nw_q;
						ph_q      <= nh_q;
						pv_q      <= 1'b1;
						pf_q      <= 1'b1;
					end
					K_MERGE: begin
						pv_q <= 1'b1;
						if (promote) begin
							pl_q <= '0;
							pt_q <= '0;
							pw_q <= sw_q;
							ph_q <= sh_q;
							pf_q <= 1'b1;
						end else begin
							pl_q <= bl_q;
							pt_q <= bt_q;
							pw_q <= bw_q;
							ph_q <= bh_q;
						end
					end
					default: pv_q <= pv_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			kind_q <= kind_d;
			bl_q   <= bl_d;
			bt_q   <= bt_d;
			bw_q   <= bw_d;
			bh_q   <= bh_d;
			cw_q   <= DIM_W'(cmd.cr - cmd.cl);
			ch_q   <= DIM_W'(cmd.cb - cmd.ct);
			nw_q   <= cmd.fw;
			nh_q   <= cmd.fh;
			ng_q   <= cmd.gen;
		end
		if (state_q == ST_MA) begin
			area_q <= mul_p;
		end
		if (state_q == ST_MB) begin
			farea_q  <= mul_p;
			a100_q   <= PROD_W'(area_q) * PROD_W'(PCT_SCALE);
			abytes_q <= WIDE_BYTES_W'(area_q) * WIDE_BYTES_W'(Bpp);
		end
		if (state_q == ST_MC) begin
			carea_q <= mul_p;
			fpct_q  <= PROD_W'(farea_q) * PROD_W'(pct);
		end
		if (fin_fire) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

>>> src/damage_rect_accumulator_core.sv
// Damage rectangle accumulator.
// Input channel: a queue-style push/full port carrying one action word (update,
// full-frame request, snapshot take or clear) with its frame and dirty-rectangle
// fields. A word is taken when push is high and full is low; two words can wait
// in the command queue while the sequencer works.
// Result channel: a queue-style empty/pop port. Each input word yields exactly
// one result word, shown while empty is low and taken when pop is high.
// Steps from acceptance to the result: clears, full-frame requests and words
// refused on their fields or on the state go from the queue straight to the
// final step; resyncs and takes (a take refused by the byte limit included)
// first pass the multiplier steps MA and MB, a merged update MA, MB and MC. The
// back-end sequencer takes a new word only once the last is finished, and runs
// its area products through one shared 14x14 multiplier.
// When the receiver stalls, the finished word holds in the result register, the
// sequencer waits in its final step and the queue fills until full rises.
// Reset clears the pending region, the stored frame and the queues, and loads
// the threshold register with 90 percent and the byte limit with 2^28.
// Configuration: APB port, threshold at byte address 0, byte limit at 4; write
// only while no word is in flight.
`default_nettype none

module damage_rect_accumulator_core import dra_pkg::*; #(
	parameter int MAX_FRAME_DIM   = 8192,
	parameter int BYTES_PER_PIXEL = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [1:0]                action,
	input  logic [DIM_W-1:0]          frame_width,
	input  logic [DIM_W-1:0]          frame_height,
	input  logic signed [COORD_W-1:0] dirty_left,
	input  logic signed [COORD_W-1:0] dirty_top,
	input  logic [COORD_W-1:0]        dirty_width,
	input  logic [COORD_W-1:0]        dirty_height,
	input  logic [GEN_W-1:0]          generation,
	input  logic                      force_resync,
	output logic                      empty,
	input  logic                      pop,
	output logic                      ok,
	output logic                      full_frame,
	output logic [OUT_POS_W-1:0]      rect_left,
	output logic [OUT_POS_W-1:0]      rect_top,
	output logic [DIM_W-1:0]          rect_width,
	output logic [DIM_W-1:0]          rect_height,
	output logic [BYTES_W-1:0]        byte_count,
	output logic [GEN_W-1:0]          snapshot_generation,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [CFG_ADDR_W-1:0]     paddr,
	input  logic [CFG_DATA_W-1:0]     pwdata,
	output logic [CFG_DATA_W-1:0]     prdata,
	output logic                      pready
);

	logic [PCT_W-1:0]   pct_q;
	logic [BYTES_W-1:0] limit_q;

	logic q_wr, q_full, q_empty, q_rd;
	cmd_t q_wdata, q_rdata;
	logic res_valid;
	res_t res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q   <= PCT_RESET;
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_PCT:   pct_q   <= pwdata[PCT_W-1:0];
				REG_LIMIT: limit_q <= pwdata[BYTES_W-1:0];
				default:   pct_q   <= pct_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PCT:   prdata = CFG_DATA_W'(pct_q);
			REG_LIMIT: prdata = CFG_DATA_W'(limit_q);
			default:   prdata = '0;
		endcase
	end

	dra_front #(
		.MAX_FRAME_DIM(MAX_FRAME_DIM)
	) u_front (
		.push         (push),
		.full         (full),
		.action       (action),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.dirty_left   (dirty_left),
		.dirty_top    (dirty_top),
		.dirty_width  (dirty_width),
		.dirty_height (dirty_height),
		.generation   (generation),
		.force_resync (force_resync),
		.q_full       (q_full),
		.q_wr         (q_wr),
		.q_data       (q_wdata)
	);

	dra_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	dra_back #(
		.BYTES_PER_PIXEL(BYTES_PER_PIXEL)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_rdata),
		.cmd_valid (!q_empty),
		.cmd_pop   (q_rd),
		.pct       (pct_q),
		.limit     (limit_q),
		.res_valid (res_valid),
		.res_pop   (pop && res_valid),
		.res       (res)
	);

	assign empty               = !res_valid;
	assign ok                  = res.ok;
	assign full_frame          = res.full_frame;
	assign rect_left           = res.rect_left;
	assign rect_top            = res.rect_top;
	assign rect_width          = res.rect_width;
	assign rect_height         = res.rect_height;
	assign byte_count          = res.byte_count;
	assign snapshot_generation = res.snapshot_generation;

endmodule

`default_nettype wire

>>> src/dra_checker.sv
`default_nettype none

`include "damage_rect_accumulator_core_assert.svh"

module dra_checker import dra_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input logic                 ok,
	input logic                 full_frame,
	input logic [OUT_POS_W-1:0] rect_left,
	input logic [OUT_POS_W-1:0] rect_top,
	input logic [DIM_W-1:0]     rect_width,
	input logic [DIM_W-1:0]     rect_height,
	input logic [BYTES_W-1:0]   byte_count,
	input logic [GEN_W-1:0]     snapshot_generation
);

	localparam int WordW = 2 + 2 * OUT_POS_W + 2 * DIM_W + BYTES_W + GEN_W;

	logic [WordW-1:0] word;
	logic             stalled, reject_shown, full_shown, bare_shown, at_origin, blank;

	assign word         = {ok, full_frame, rect_left, rect_top, rect_width, rect_height,
		byte_count, snapshot_generation};
	assign stalled      = !empty && !pop;
	assign reject_shown = !empty && !ok;
	assign full_shown   = !empty && full_frame;
	assign bare_shown   = !empty && ok && (rect_width == '0);
	assign at_origin    = (rect_left == '0) && (rect_top == '0);
	assign blank        = !full_frame && at_origin && (rect_width == '0) &&
		(rect_height == '0) && (byte_count == '0) && (snapshot_generation == '0);

	// A waiting word that is not taken must still be there, unchanged.
	`DRA_ASSERT_NXT(a_hold, clk, arst_n, stalled, !empty && $stable(word), "stalled word changed")

	// A refused action reports nothing else.
	`DRA_ASSERT_IMP(a_reject_zero, clk, arst_n, reject_shown, blank, "rejected word carries data")

	// Whole-frame damage always starts at the origin.
	`DRA_ASSERT_IMP(a_full_origin, clk, arst_n, full_shown, ok && at_origin, "full frame off origin")

	// Only a clear gives an accepted word with no width, and it is blank.
	`DRA_ASSERT_IMP(a_clear_blank, clk, arst_n, bare_shown, blank, "widthless word not blank")

endmodule

bind damage_rect_accumulator_core dra_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/damage_rect_accumulator_core_tb.sv
`default_nettype none

module damage_rect_accumulator_core_tb import dra_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASES      = 6;
	localparam int RANDOM_WORDS = 170;

	typedef struct {
		act_t               act;
		bit [DIM_W-1:0]     fw;
		bit [DIM_W-1:0]     fh;
		shortint            dl;
		shortint            dt;
		bit [COORD_W-1:0]   dw;
		bit [COORD_W-1:0]   dh;
		bit [GEN_W-1:0]     gen;
		bit                 frc;
	} damage_word_t;

	// Tracks the stored frame and the pending damage box, and holds the result words
	// still owed by the block in arrival order.
	class damage_scoreboard;
		localparam int     MAX_DIM = 8192;
		localparam longint BPP     = 4;

		bit [PCT_W-1:0]   share_pct;
		bit [BYTES_W-1:0] byte_limit;
		bit [DIM_W-1:0]   frame_w, frame_h;
		bit [GEN_W-1:0]   frame_gen;
		bit               frame_kept;
		bit [DIM_W-1:0]   box_l, box_t, box_w, box_h;
		bit               box_valid, box_full;
		res_t             owed_q[$];
		int               mismatches, checked, resyncs, merges, promotions, snapshots, rejects;

		function new();
			share_pct = PCT_RESET;
			byte_limit = LIMIT_RESET;
			drop_frame();
		endfunction

		function void drop_frame();
			frame_w = '0;
			frame_h = '0;
			frame_gen = '0;
			frame_kept = 1'b0;
			box_l = '0;
			box_t = '0;
			box_w = '0;
			box_h = '0;
			box_valid = 1'b0;
			box_full = 1'b0;
		endfunction

		function void box_to_frame();
			box_l = '0;
			box_t = '0;
			box_w = frame_w;
			box_h = frame_h;
			box_valid = 1'b1;
			box_full = 1'b1;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void set_register(logic idx, bit [CFG_DATA_W-1:0] value);
			if (idx == REG_PCT)
				share_pct = value[PCT_W-1:0];
			else
				byte_limit = value[BYTES_W-1:0];
		endfunction

		function string show(res_t r);
			return $sformatf("ok=%0d full=%0d rect=(%0d,%0d %0dx%0d) bytes=%0d gen=%0h",
				r.ok, r.full_frame, r.rect_left, r.rect_top, r.rect_width, r.rect_height,
				r.byte_count, r.snapshot_generation);
		endfunction

		function void flag(string what, string detail);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: %s: %s", $time, what, detail);
		endfunction

		function void check_register(logic idx, bit [CFG_DATA_W-1:0] got);
			bit [CFG_DATA_W-1:0] want;
			want = (idx == REG_PCT) ? CFG_DATA_W'(share_pct) : CFG_DATA_W'(byte_limit);
			if (got !== want)
				flag("register readback", $sformatf("index %0d expected %0h, got %0h",
					idx, want, got));
		endfunction

		function res_t apply_update(bit [DIM_W-1:0] fw, bit [DIM_W-1:0] fh, shortint dl,
				shortint dt, bit [COORD_W-1:0] dw, bit [COORD_W-1:0] dh,
				bit [GEN_W-1:0] gen, bit frc);
			res_t res;
			longint fwl, fhl, l, t, r, b, pr, pb, bytes;
			bit clip_ok;
			res = '0;
			if (fw == 0 || fh == 0 || fw > MAX_DIM || fh > MAX_DIM || gen == 0)
				return res;
			fwl = longint'(fw);
			fhl = longint'(fh);
			l = (dl > 0) ? longint'(dl) : 0;
			t = (dt > 0) ? longint'(dt) : 0;
			r = longint'(dl) + longint'(dw);
			if (r > fwl)
				r = fwl;
			b = longint'(dt) + longint'(dh);
			if (b > fhl)
				b = fhl;
			clip_ok = dw != 0 && dh != 0 && r > l && b > t;
			if (frc || fw != frame_w || fh != frame_h || gen != frame_gen || !clip_ok ||
					!frame_kept) begin
				frame_w = fw;
				frame_h = fh;
				frame_gen = gen;
				frame_kept = 1'b1;
				box_to_frame();
				bytes = fwl * fhl * BPP;
				resyncs++;
			end else begin
				bytes = (r - l) * (b - t) * BPP;
				if (box_valid) begin
					pr = longint'(box_l) + longint'(box_w);
					pb = longint'(box_t) + longint'(box_h);
					if (longint'(box_l) < l)
						l = longint'(box_l);
					if (longint'(box_t) < t)
						t = longint'(box_t);
					if (pr > r)
						r = pr;
					if (pb > b)
						b = pb;
				end
				box_l = DIM_W'(l);
				box_t = DIM_W'(t);
				box_w = DIM_W'(r - l);
				box_h = DIM_W'(b - t);
				box_valid = 1'b1;
				merges++;
				if (longint'(box_w) * longint'(box_h) * 100 >=
						longint'(frame_w) * longint'(frame_h) * longint'(share_pct)) begin
					box_to_frame();
					promotions++;
				end
			end
			res.ok = 1'b1;
			res.full_frame = box_full;
			res.rect_left = box_l[OUT_POS_W-1:0];
			res.rect_top = box_t[OUT_POS_W-1:0];
			res.rect_width = box_w;
			res.rect_height = box_h;
			res.byte_count = bytes[BYTES_W-1:0];
			return res;
		endfunction

		function res_t request_full(bit [GEN_W-1:0] gen);
			res_t res;
			res = '0;
			if (gen == 0 || !frame_kept || frame_w == 0 || frame_h == 0)
				return res;
			frame_gen = gen;
			box_to_frame();
			res.ok = 1'b1;
			res.full_frame = 1'b1;
			res.rect_width = frame_w;
			res.rect_height = frame_h;
			return res;
		endfunction

		function res_t take_box();
			res_t res;
			longint bytes;
			res = '0;
			if (!box_valid || !frame_kept)
				return res;
			res.full_frame = box_full;
			if (box_full) begin
				res.rect_width = frame_w;
				res.rect_height = frame_h;
			end else begin
				res.rect_left = box_l[OUT_POS_W-1:0];
				res.rect_top = box_t[OUT_POS_W-1:0];
				res.rect_width = box_w;
				res.rect_height = box_h;
			end
			bytes = longint'(res.rect_width) * longint'(res.rect_height) * BPP;
			if (bytes > longint'(byte_limit)) begin
				res = '0;
				return res;
			end
			res.ok = 1'b1;
			res.byte_count = box_full ? '0 : bytes[BYTES_W-1:0];
			res.snapshot_generation = frame_gen;
			box_l = '0;
			box_t = '0;
			box_w = '0;
			box_h = '0;
			box_valid = 1'b0;
			box_full = 1'b0;
			snapshots++;
			return res;
		endfunction

		function void note_action(act_t act, bit [DIM_W-1:0] fw, bit [DIM_W-1:0] fh,
				shortint dl, shortint dt, bit [COORD_W-1:0] dw, bit [COORD_W-1:0] dh,
				bit [GEN_W-1:0] gen, bit frc);
			res_t res;
			res = '0;
			case (act)
				ACT_UPDATE: res = apply_update(fw, fh, dl, dt, dw, dh, gen, frc);
				ACT_FULL:   res = request_full(gen);
				ACT_TAKE:   res = take_box();
				default: begin
					drop_frame();
					res.ok = 1'b1;
				end
			endcase
			if (!res.ok)
				rejects++;
			owed_q.push_back(res);
		endfunction

		function void check_result(res_t got);
			res_t want;
			string bad;
			checked++;
			if (owed_q.size() == 0) begin
				flag("result word with nothing expected", show(got));
				return;
			end
			want = owed_q.pop_front();
			bad = "";
			if (got.ok !== want.ok)
				bad = {bad, " ok"};
			if (got.full_frame !== want.full_frame)
				bad = {bad, " full_frame"};
			if (got.rect_left !== want.rect_left)
				bad = {bad, " rect_left"};
			if (got.rect_top !== want.rect_top)
				bad = {bad, " rect_top"};
			if (got.rect_width !== want.rect_width)
				bad = {bad, " rect_width"};
			if (got.rect_height !== want.rect_height)
				bad = {bad, " rect_height"};
			if (got.byte_count !== want.byte_count)
				bad = {bad, " byte_count"};
			if (got.snapshot_generation !== want.snapshot_generation)
				bad = {bad, " snapshot_generation"};
			if (bad != "")
				flag({"wrong", bad}, {"expected ", show(want), ", got ", show(got)});
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      push = 1'b0;
	logic                      full;
	logic [1:0]                action = '0;
	logic [DIM_W-1:0]          frame_width = '0;
	logic [DIM_W-1:0]          frame_height = '0;
	logic signed [COORD_W-1:0] dirty_left = '0;
	logic signed [COORD_W-1:0] dirty_top = '0;
	logic [COORD_W-1:0]        dirty_width = '0;
	logic [COORD_W-1:0]        dirty_height = '0;
	logic [GEN_W-1:0]          generation = '0;
	logic                      force_resync = 1'b0;
	logic                      empty;
	logic                      pop = 1'b0;
	logic                      ok;
	logic                      full_frame;
	logic [OUT_POS_W-1:0]      rect_left;
	logic [OUT_POS_W-1:0]      rect_top;
	logic [DIM_W-1:0]          rect_width;
	logic [DIM_W-1:0]          rect_height;
	logic [BYTES_W-1:0]        byte_count;
	logic [GEN_W-1:0]          snapshot_generation;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0]     paddr = '0;
	logic [CFG_DATA_W-1:0]     pwdata = '0;
	logic [CFG_DATA_W-1:0]     prdata;
	logic                      pready;

	damage_scoreboard sb;
	int send_gap_max = 0;
	int recv_stall_max = 0;
	int cur_w = 32;
	int cur_h = 24;
	bit [GEN_W-1:0] cur_gen = 32'd3;
	int cycle_count = 0;

	damage_rect_accumulator_core dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && push && !full)
			sb.note_action(act_t'(action), frame_width, frame_height, dirty_left, dirty_top,
				dirty_width, dirty_height, generation, force_resync);
		if (arst_n && pop && !empty)
			sb.check_result(res_t'({ok, full_frame, rect_left, rect_top, rect_width,
				rect_height, byte_count, snapshot_generation}));
	end

	function automatic int pick_gap_max();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 3;
			default: return 16;
		endcase
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(0, 19))
			0: return 8192;
			1, 2: return $urandom_range(1, 8192);
			default: return $urandom_range(1, 48);
		endcase
	endfunction

	function automatic damage_word_t make_word(act_t act, int fw, int fh, int dl, int dt,
			int dw, int dh, bit [GEN_W-1:0] gen, bit frc);
		damage_word_t w;
		w.act = act;
		w.fw = fw[DIM_W-1:0];
		w.fh = fh[DIM_W-1:0];
		w.dl = dl[COORD_W-1:0];
		w.dt = dt[COORD_W-1:0];
		w.dw = dw[COORD_W-1:0];
		w.dh = dh[COORD_W-1:0];
		w.gen = gen;
		w.frc = frc;
		return w;
	endfunction

	// Mostly well-formed traffic on the current frame so that merges build up; a small
	// share of words is pure noise over every field.
	function automatic damage_word_t random_word();
		damage_word_t w;
		int sel;
		sel = $urandom_range(0, 99);
		w = make_word(ACT_UPDATE, cur_w, cur_h, 0, 0, 0, 0, cur_gen, 1'b0);
		if (sel >= 95) begin
			w.act = act_t'($urandom_range(0, 3));
			w.fw = DIM_W'($urandom_range(0, 16383));
			w.fh = DIM_W'($urandom_range(0, 16383));
			w.dl = shortint'($urandom_range(0, 65535));
			w.dt = shortint'($urandom_range(0, 65535));
			w.dw = COORD_W'($urandom_range(0, 65535));
			w.dh = COORD_W'($urandom_range(0, 65535));
			w.gen = $urandom_range(0, 1) ? $urandom : '0;
			w.frc = 1'($urandom_range(0, 1));
			return w;
		end
		if (sel >= 92)
			w.act = ACT_CLEAR;
		else if (sel >= 82)
			w.act = ACT_FULL;
		else if (sel >= 62)
			w.act = ACT_TAKE;
		w.dl = shortint'(int'($urandom_range(0, cur_w + 1)) - 2);
		w.dt = shortint'(int'($urandom_range(0, cur_h + 1)) - 2);
		w.dw = ($urandom_range(0, 29) == 0) ? 16'd0 : 16'($urandom_range(1, cur_w / 4 + 1));
		w.dh = ($urandom_range(0, 29) == 0) ? 16'd0 : 16'($urandom_range(1, cur_h / 4 + 1));
		if ($urandom_range(0, 24) == 0)
			w.frc = 1'b1;
		if ($urandom_range(0, 29) == 0)
			w.gen = $urandom_range(0, 1) ? '0 : $urandom;
		return w;
	endfunction

	task automatic push_word(input damage_word_t w);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action <= w.act;
		frame_width <= w.fw;
		frame_height <= w.fh;
		dirty_left <= w.dl;
		dirty_top <= w.dt;
		dirty_width <= w.dw;
		dirty_height <= w.dh;
		generation <= w.gen;
		force_resync <= w.frc;
		push <= 1'b1;
		do @(posedge clk); while (full);
	endtask

	// Writes a register, then reads it back in a second transfer.
	task automatic program_reg(input logic idx, input bit [CFG_DATA_W-1:0] value);
		bit [CFG_DATA_W-1:0] readback;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, value);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		sb.check_register(idx, readback);
	endtask

	// The extra edge first lets the monitor note the last accepted word.
	task automatic settle(input int tail);
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	initial begin
		int stall;
		int taken;
		taken = 0;
		forever begin
			if (taken % 50 == 0)
				recv_stall_max = pick_gap_max();
			stall = $urandom_range(0, recv_stall_max);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			taken++;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int pct_list[PHASES];
		int unsigned limit_list[PHASES];
		int phase;
		int n;
		sb = new();
		pct_list = '{90, 0, 100, 127, 1, 50};
		limit_list = '{LIMIT_RESET, LIMIT_RESET, 4096, 0, LIMIT_RESET, 4096};
		pct_list[5] = $urandom_range(2, 99);
		limit_list[5] = $urandom_range(0, 16384);
		cur_gen = $urandom_range(1, 32'hFFFF_FFFF);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (phase = 0; phase < PHASES; phase++) begin
			settle(8);
			program_reg(REG_PCT, pct_list[phase]);
			program_reg(REG_LIMIT, limit_list[phase]);
			if (phase == 0) begin
				// Rejections before any frame exists, then bad frame sizes and generation.
				push_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 32'd0, 1'b0));
				push_word(make_word(ACT_FULL, 0, 0, 0, 0, 0, 0, 32'd5, 1'b0));
				push_word(make_word(ACT_UPDATE, 0, 10, 0, 0, 1, 1, 32'd1, 1'b0));
				push_word(make_word(ACT_UPDATE, 10, 0, 0, 0, 1, 1, 32'd1, 1'b0));
				push_word(make_word(ACT_UPDATE, 8193, 10, 0, 0, 1, 1, 32'd1, 1'b0));
				push_word(make_word(ACT_UPDATE, 10, 16383, 0, 0, 1, 1, 32'd1, 1'b0));
				push_word(make_word(ACT_UPDATE, 10, 10, 0, 0, 1, 1, 32'd0, 1'b0));
				// Largest frame: the take sits exactly on the reset byte limit.
				push_word(make_word(ACT_UPDATE, 8192, 8192, 0, 0, 1, 1, 32'hFFFF_FFFF, 1'b0));
				push_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 32'd0, 1'b0));
				push_word(make_word(ACT_UPDATE, 8192, 8192, -32768, -32768, 65535, 65535,
					32'hFFFF_FFFF, 1'b0));
				push_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 32'd0, 1'b0));
				push_word(make_word(ACT_UPDATE, 100, 50, 3, 4, 5, 6, 32'd7, 1'b0));
				push_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 32'd0, 1'b0));
				push_word(make_word(ACT_UPDATE, 100, 50, 3, 4, 5, 6, 32'd7, 1'b0));
				push_word(make_word(ACT_UPDATE, 100, 50, -5, -5, 10, 10, 32'd7, 1'b0));
				push_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 32'd0, 1'b0));
				push_word(make_word(ACT_UPDATE, 100, 50, 32767, 32767, 9, 9, 32'd7, 1'b0));
				push_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 32'd0, 1'b0));
				push_word(make_word(ACT_UPDATE, 100, 50, 90, 40, 20, 20, 32'd7, 1'b0));
				push_word(make_word(ACT_UPDATE, 100, 50, 1, 1, 0, 5, 32'd7, 1'b0));
				push_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 32'd0, 1'b0));
				// Exactly ninety percent of the frame promotes the box.
				push_word(make_word(ACT_UPDATE, 100, 50, 0, 0, 100, 45, 32'd7, 1'b0));
				push_word(make_word(ACT_UPDATE, 100, 50, 1, 1, 1, 1, 32'd7, 1'b1));
				push_word(make_word(ACT_UPDATE, 100, 50, 1, 1, 1, 1, 32'd8, 1'b0));
				push_word(make_word(ACT_FULL, 0, 0, 0, 0, 0, 0, 32'd0, 1'b0));
				push_word(make_word(ACT_FULL, 0, 0, 0, 0, 0, 0, 32'd9, 1'b0));
				push_word(make_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 32'd0, 1'b0));
				push_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 32'd0, 1'b0));
				push_word(make_word(ACT_FULL, 0, 0, 0, 0, 0, 0, 32'd9, 1'b0));
			end
			for (n = 0; n < RANDOM_WORDS; n++) begin
				if (n % 64 == 0)
					send_gap_max = pick_gap_max();
				if ($urandom_range(0, 24) == 0) begin
					cur_w = pick_dim();
					cur_h = pick_dim();
				end
				if ($urandom_range(0, 29) == 0)
					cur_gen = $urandom_range(1, 32'hFFFF_FFFF);
				push_word(random_word());
			end
			push <= 1'b0;
		end
		settle(10);
		$display("Checked %0d result words over %0d threshold and byte-limit settings.",
			sb.checked, PHASES);
		$display("Seen: %0d resyncs, %0d merges, %0d promotions, %0d snapshots, %0d rejects.",
			sb.resyncs, sb.merges, sb.promotions, sb.snapshots, sb.rejects);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
